// ===== rtl/rbc_pkg.sv =====
`default_nettype none
package rbc_pkg;

  localparam int IN_LIMBS  = 4;
  localparam int OUT_COLS  = 4;
  localparam int TBL_ROWS  = 4;
  localparam int TBL_COLS  = 4;
  localparam int WORD_W    = 64;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int RED_STEPS = PROD_W;
  // multiply (2) + reduction cells + adder tree first level
  localparam int PIPE_LAT  = 2 + RED_STEPS + 1;

  localparam logic [1:0] OP_LOAD_W = 2'd0;
  localparam logic [1:0] OP_LOAD_M = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  // reduction packet handed from cell to cell
  typedef struct packed {
    word_t              rem;
    logic [PROD_W-1:0]  dvd;
    word_t              m;
    logic               en;
  } rbc_red_t;

  // (a + b) mod m for a, b < m
  function automatic word_t add_mod(word_t a, word_t b, word_t m);
    logic [WORD_W:0] s;
    logic [WORD_W:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, m};
    if (s >= {1'b0, m}) begin
      return d[WORD_W-1:0];
    end
    return s[WORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rbc_cell.sv =====
`default_nettype none
module rbc_cell import rbc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     adv,
  input  wire rbc_red_t d_i,
  output rbc_red_t      d_o
);

  rbc_red_t        d_r;
  rbc_red_t        d_nxt;
  logic [WORD_W:0] sh;
  logic [WORD_W:0] diff;

  // one restoring shift-subtract step
  always_comb begin
    sh    = {d_i.rem, d_i.dvd[PROD_W-1]};
    diff  = sh - {1'b0, d_i.m};
    d_nxt = d_i;
    d_nxt.dvd = {d_i.dvd[PROD_W-2:0], 1'b0};
    d_nxt.rem = (sh >= {1'b0, d_i.m}) ? diff[WORD_W-1:0] : sh[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

// ===== rtl/rbc_mulmod.sv =====
`default_nettype none
module rbc_mulmod import rbc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  adv,
  input  wire word_t x_i,
  input  wire word_t w_i,
  input  wire word_t m_i,
  input  wire logic  en_i,
  output rbc_red_t   d_o
);

  localparam int HW = WORD_W / 2;

  word_t    ll_r, lh_r, hl_r, hh_r, m1_r;
  logic     en1_r;
  rbc_red_t p2_nxt;
  rbc_red_t p2_r;
  rbc_red_t chain [RED_STEPS+1];

  // stage 1: four half-width partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      ll_r  <= WORD_W'(x_i[HW-1:0]) * WORD_W'(w_i[HW-1:0]);
      lh_r  <= WORD_W'(x_i[HW-1:0]) * WORD_W'(w_i[WORD_W-1:HW]);
      hl_r  <= WORD_W'(x_i[WORD_W-1:HW]) * WORD_W'(w_i[HW-1:0]);
      hh_r  <= WORD_W'(x_i[WORD_W-1:HW]) * WORD_W'(w_i[WORD_W-1:HW]);
      m1_r  <= m_i;
      en1_r <= en_i;
    end
  end

  // stage 2: full product
  always_comb begin
    p2_nxt.rem = '0;
    p2_nxt.dvd = {hh_r, ll_r} + (PROD_W'(lh_r) << HW) + (PROD_W'(hl_r) << HW);
    p2_nxt.m   = m1_r;
    p2_nxt.en  = en1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r <= p2_nxt;
    end
  end

  assign chain[0] = p2_r;

  for (genvar i = 0; i < RED_STEPS; i++) begin : g_cell
    rbc_cell u_cell (
      .clk (clk),
      .adv (adv),
      .d_i (chain[i]),
      .d_o (chain[i+1])
    );
  end

  assign d_o = chain[RED_STEPS];

endmodule
`default_nettype wire

// ===== rtl/rns_base_conversion_mac_array.sv =====
`default_nettype none
// RNS fast base conversion. Load items write the weight table (opcode 0,
// entry limb/column) and the column moduli (opcode 1); a data item (opcode 2)
// gives one result: per output column p, sum over limbs of (x*w mod m_p),
// taken mod m_p. Columns at or above active_columns, or with a zero modulus,
// read 0. One item is taken every cycle unless the input stalls. A data
// item's result passes the first multiplier stage, loaded by the accepting
// edge, then the second multiplier stage, the row of 128 shift-subtract
// reduction cells and the 2-level modular adder tree. Load items take
// effect for the very next item and produce no result. The whole pipe
// advances together, so the input stalls only while a result sits
// unclaimed in the output register. Reading a weight or modulus never
// written gives an undefined result.
module rns_base_conversion_mac_array import rbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [1:0]  in_limb_index,
  input  wire logic [1:0]  in_column_index,
  input  wire logic [63:0] in_setup_value,
  input  wire logic [63:0] in_residue_0,
  input  wire logic [63:0] in_residue_1,
  input  wire logic [63:0] in_residue_2,
  input  wire logic [63:0] in_residue_3,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_0,
  output logic [63:0]      out_1,
  output logic [63:0]      out_2,
  output logic [63:0]      out_3
);

  logic [2:0]          active_columns_r;
  word_t               weight_r  [TBL_ROWS*TBL_COLS];
  word_t               modulus_r [TBL_COLS];
  logic [PIPE_LAT-1:0] vld_r;
  logic                out_valid_r;
  word_t               out_r [TBL_COLS];
  logic                adv;
  logic                in_acc;
  word_t               res [TBL_ROWS];
  rbc_red_t            red [TBL_ROWS][TBL_COLS];
  word_t               s01_r [TBL_COLS];
  word_t               s23_r [TBL_COLS];
  word_t               m_r   [TBL_COLS];
  logic                en_r  [TBL_COLS];

  // whole pipe moves unless the held result is being refused
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  assign res[0] = in_residue_0;
  assign res[1] = in_residue_1;
  assign res[2] = in_residue_2;
  assign res[3] = in_residue_3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_columns_r <= 3'd4;
    end else if (cfg_wr_en) begin
      active_columns_r <= cfg_wr_data;
    end
  end

  // tables: no reset, undefined until written
  always_ff @(posedge clk) begin
    if (in_acc && in_opcode == OP_LOAD_W
        && 32'(in_limb_index) < IN_LIMBS && 32'(in_column_index) < OUT_COLS) begin
      weight_r[{in_limb_index, in_column_index}] <= in_setup_value;
    end
    if (in_acc && in_opcode == OP_LOAD_M && 32'(in_column_index) < OUT_COLS) begin
      modulus_r[in_column_index] <= in_setup_value;
    end
  end

  // one multiply/reduce unit per limb and column
  for (genvar p = 0; p < TBL_COLS; p++) begin : g_col
    logic col_en;
    assign col_en = (p < OUT_COLS) && (3'(p) < active_columns_r)
                    && (modulus_r[p] != '0);
    for (genvar q = 0; q < TBL_ROWS; q++) begin : g_limb
      if (q < IN_LIMBS) begin : g_unit
        rbc_mulmod u_mulmod (
          .clk  (clk),
          .adv  (adv),
          .x_i  (res[q]),
          .w_i  (weight_r[q*TBL_COLS+p]),
          .m_i  (modulus_r[p]),
          .en_i (col_en),
          .d_o  (red[q][p])
        );
      end else begin : g_none
        assign red[q][p] = '0;
      end
    end

    // modular adder tree, first level
    always_ff @(posedge clk) begin
      if (adv) begin
        s01_r[p] <= add_mod(red[0][p].rem, red[1][p].rem, red[0][p].m);
        s23_r[p] <= add_mod(red[2][p].rem, red[3][p].rem, red[0][p].m);
        m_r[p]   <= red[0][p].m;
        en_r[p]  <= red[0][p].en;
      end
    end

    // second level straight into the output register
    always_ff @(posedge clk) begin
      if (adv) begin
        out_r[p] <= en_r[p] ? add_mod(s01_r[p], s23_r[p], m_r[p]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_LAT-2:0], in_acc && in_opcode == OP_DATA};
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_0     = out_r[0];
  assign out_1     = out_r[1];
  assign out_2     = out_r[2];
  assign out_3     = out_r[3];

  // data items enter the valid line, load items never do
  a_data_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == OP_DATA |=> vld_r[0])
    else $error("accepted data item missing from pipe");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode != OP_DATA |=> !vld_r[0])
    else $error("non-data item entered pipe");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && out_valid_r)
    else $error("pipe moved while stalled");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vld_r[PIPE_LAT-1]))
    else $error("result without item in last stage");

endmodule
`default_nettype wire
